// ===== hw/rtl/kdl_pkg.sv =====
// ---------------------------------------------------------------------------
// kdl_pkg: shared types and constants for the keyed table lookup block
// Field widths, command and status codes, sequencer states, entry layout and
// the fixed-point constants of the volume mapping.
// ---------------------------------------------------------------------------
package kdl_pkg;

	localparam int NUM_CATEGORIES_DEF = 8;
	localparam int TABLE_SLOTS_DEF    = 16;

	localparam int CAT_W    = 3;
	localparam int KEY_W    = 8;
	localparam int SID_W    = 32;
	localparam int PITCH_W  = 16;
	localparam int VOL_W    = 15;
	localparam int STATUS_W = 3;

	localparam int S_TDATA_W = 128;
	localparam int M_TDATA_W = 80;

	// 100 percent in units of 1/256 percent
	localparam logic [VOL_W-1:0] FULL_SCALE = 15'd25600;

	// floor(x / 100) == (x * VMAP_RECIP) >> VMAP_SHIFT for every x below 2^22
	localparam int VMAP_SHIFT = 29;
	localparam logic [22:0] VMAP_RECIP = 23'd5368710;

	typedef enum logic {
		CMD_DEFINE = 1'b0,
		CMD_LOOKUP = 1'b1
	} kdl_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_ADDED     = 3'd0,
		STAT_REDEFINED = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_EXACT     = 3'd3,
		STAT_DEFAULT   = 3'd4,
		STAT_MISS      = 3'd5,
		STAT_DISABLED  = 3'd6
	} kdl_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_SCAN,
		ST_MAP,
		ST_DONE
	} kdl_state_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [SID_W-1:0]   sound;
		logic [PITCH_W-1:0] pitch_high;
		logic [PITCH_W-1:0] pitch_low;
		logic [VOL_W-1:0]   volume_high;
		logic [VOL_W-1:0]   volume_low;
	} kdl_entry_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} kdl_mem_ctl_t;

endpackage

// ===== hw/rtl/kdl_entry_mem.sv =====
// ---------------------------------------------------------------------------
// kdl_entry_mem: entry storage for all category tables
// Single-port synchronous memory, one read or one write per cycle, registered
// read data. Contents are undefined until written.
// ---------------------------------------------------------------------------
module kdl_entry_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                  clk,
	input  kdl_pkg::kdl_mem_ctl_t ctl,
	input  logic [AW-1:0]         addr,
	input  kdl_pkg::kdl_entry_t   wdata,
	output kdl_pkg::kdl_entry_t   rdata
);
	import kdl_pkg::*;

	kdl_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== hw/rtl/kdl_count_mem.sv =====
// ---------------------------------------------------------------------------
// kdl_count_mem: per-category fill counts
// Synchronous memory with registered read; a valid bit per category, cleared
// at reset, makes an unwritten count read as zero.
// ---------------------------------------------------------------------------
module kdl_count_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3,
	parameter int DW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);
	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

endmodule

// ===== hw/rtl/kdl_vmap.sv =====
// ---------------------------------------------------------------------------
// kdl_vmap: volume range mapping
// Three-stage pipe: low + trunc((high - low) * request / 25600), then the
// optional clip to high and saturation to 0..25600.
// ---------------------------------------------------------------------------
module kdl_vmap (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [kdl_pkg::VOL_W-1:0] volume_high,
	input  logic [kdl_pkg::VOL_W-1:0] volume_low,
	input  logic [kdl_pkg::VOL_W-1:0] volume_request,
	input  logic                      clip_to_high,
	output logic                      done,
	output logic [kdl_pkg::VOL_W-1:0] mapped_volume
);
	import kdl_pkg::*;

	logic             vld_s1, vld_s2, vld_s3;
	logic [VOL_W-1:0] hi_s1, lo_s1, req_s1;
	logic [VOL_W-1:0] hi_s2, lo_s2, req_s2;
	logic             clip_s1, full_s1, neg_s1;
	logic             clip_s2, full_s2, neg_s2;
	logic [29:0]      prod_s1;
	logic [44:0]      prod_s2;
	logic [VOL_W-1:0] vol_s3;

	logic             neg_c;
	logic [VOL_W-1:0] mag_c;
	logic [15:0]      quot_c;
	logic signed [17:0] lo_c, quot_x_c, hi_x_c, sum_c, clip_c, sat_c;

	always_comb begin
		neg_c = volume_high < volume_low;
		mag_c = neg_c ? (volume_low - volume_high) : (volume_high - volume_low);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		hi_s1   <= volume_high;
		lo_s1   <= volume_low;
		req_s1  <= volume_request;
		clip_s1 <= clip_to_high;
		full_s1 <= (volume_low == '0) && (volume_high == FULL_SCALE);
		neg_s1  <= neg_c;
		prod_s1 <= 30'(mag_c) * 30'(volume_request);

		hi_s2   <= hi_s1;
		lo_s2   <= lo_s1;
		req_s2  <= req_s1;
		clip_s2 <= clip_s1;
		full_s2 <= full_s1;
		neg_s2  <= neg_s1;
		// divide by 256 is the shift, divide by 100 the reciprocal multiply
		prod_s2 <= 45'(prod_s1[29:8]) * 45'(VMAP_RECIP);

		vol_s3  <= sat_c[VOL_W-1:0];
	end

	always_comb begin
		quot_c   = prod_s2[44:VMAP_SHIFT];
		lo_c     = signed'({3'b000, lo_s2});
		hi_x_c   = signed'({3'b000, hi_s2});
		quot_x_c = signed'({2'b00, quot_c});
		if (full_s2) begin
			sum_c = signed'({3'b000, req_s2});
		end else if (neg_s2) begin
			sum_c = lo_c - quot_x_c;
		end else begin
			sum_c = lo_c + quot_x_c;
		end
		clip_c = (clip_s2 && (sum_c > hi_x_c)) ? hi_x_c : sum_c;
		if (clip_c < 18'sd0) begin
			sat_c = '0;
		end else if (clip_c > signed'({3'b000, FULL_SCALE})) begin
			sat_c = signed'({3'b000, FULL_SCALE});
		end else begin
			sat_c = clip_c;
		end
	end

	assign done          = vld_s3;
	assign mapped_volume = vol_s3;

endmodule

// ===== hw/rtl/keyed_table_with_default_lookup.sv =====
// ---------------------------------------------------------------------------
// keyed_table_with_default_lookup: per-category keyed table with default entry
// Define commands add or rewrite keyed entries; lookups return an exact or
// default entry with the request volume mapped into its range.
// ---------------------------------------------------------------------------
// Usage
//   Input channel s_*: one command per transfer. s_tuser carries the command
//   (0 define, 1 lookup), s_tdata the operands. Output channel m_*: one result
//   per command, m_tuser the status, m_tdata the entry data and mapped volume.
//   cfg_we/cfg_data write the sound_disabled register; write it only while
//   no command is in flight.
// Sequence
//   One command at a time. The fill count is fetched first, then the scan
//   walks the table one entry per cycle out of the single-port entry memory;
//   a table holds n entries with n <= TABLE_SLOTS-1. A lookup with a nonzero
//   key that misses it does a second pass for the default key, and a hit
//   lookup then passes through the volume pipe before the output register.
//   Disabled commands and out-of-range categories skip the count fetch and
//   the scan and go straight to the result.
// Reset and stall
//   Reset clears the fill counts (entries themselves are never cleared; only
//   entries below the fill count are read) and the disable flag. The result
//   sits in an output register; s_tready stays low from acceptance until the
//   result has moved into that register, so a stalled receiver holds back at
//   most one further command.
// ---------------------------------------------------------------------------
module keyed_table_with_default_lookup #(
	parameter int NUM_CATEGORIES = kdl_pkg::NUM_CATEGORIES_DEF,
	parameter int TABLE_SLOTS    = kdl_pkg::TABLE_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: sound_disabled
	input  logic                          cfg_we,
	input  logic                          cfg_data,
	// command stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [2:0] category, [10:3] surface_key, [42:11] sound_id, [58:43] pitch_high,
	// [74:59] pitch_low, [89:75] volume_high, [104:90] volume_low,
	// [119:105] volume_request, [120] clip_to_high, [127:121] zero
	input  logic [kdl_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] command
	input  logic                          s_tuser,
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] found_sound_id, [47:32] found_pitch_high, [63:48] found_pitch_low,
	// [78:64] mapped_volume, [79] zero
	output logic [kdl_pkg::M_TDATA_W-1:0] m_tdata,
	// [2:0] status
	output logic [kdl_pkg::STATUS_W-1:0]  m_tuser
);
	import kdl_pkg::*;

	localparam int DEPTH  = NUM_CATEGORIES * TABLE_SLOTS;
	localparam int ENT_AW = $clog2(DEPTH);
	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int CNT_AW = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;

	// input field slices
	logic [CAT_W-1:0]   in_cat;
	logic [KEY_W-1:0]   in_key;
	logic [SID_W-1:0]   in_sid;
	logic [PITCH_W-1:0] in_ph, in_pl;
	logic [VOL_W-1:0]   in_vh, in_vl, in_vreq;
	logic               in_clip;

	assign in_cat  = s_tdata[2:0];
	assign in_key  = s_tdata[10:3];
	assign in_sid  = s_tdata[42:11];
	assign in_ph   = s_tdata[58:43];
	assign in_pl   = s_tdata[74:59];
	assign in_vh   = s_tdata[89:75];
	assign in_vl   = s_tdata[104:90];
	assign in_vreq = s_tdata[119:105];
	assign in_clip = s_tdata[120];

	// control state
	kdl_state_t state_q, state_d;
	logic       disabled_q;
	logic       pend_s1;
	logic       m_tvalid_q;

	// command held for the duration of the scan
	kdl_cmd_t           cmd_q;
	logic [CAT_W-1:0]   cat_q;
	logic [KEY_W-1:0]   key_q;
	logic [SID_W-1:0]   sid_q;
	logic [PITCH_W-1:0] ph_q, pl_q;
	logic [VOL_W-1:0]   vh_q, vl_q, vreq_q;
	logic               clip_q;

	// scan bookkeeping
	logic [SLOT_W-1:0]  n_q;
	logic [SLOT_W-1:0]  rd_idx_q;
	logic [SLOT_W-1:0]  idx_s1;
	logic               pass_q;      // 0 exact key, 1 default key

	// pending result
	kdl_status_t        res_status_q;
	logic [SID_W-1:0]   res_sid_q;
	logic [PITCH_W-1:0] res_ph_q, res_pl_q;
	logic [VOL_W-1:0]   res_vol_q;

	// output register
	logic [M_TDATA_W-1:0] m_tdata_q;
	kdl_status_t          m_tuser_q;

	// memory and map unit connections
	kdl_mem_ctl_t        ent_ctl;
	logic [ENT_AW-1:0]   ent_addr;
	kdl_entry_t          ent_wdata, ent_rdata;
	logic [SLOT_W-1:0]   ent_slot;
	logic                cnt_rd, cnt_we;
	logic [SLOT_W-1:0]   cnt_rdata;
	logic                map_start, map_done;
	logic [VOL_W-1:0]    map_vol;

	// decisions
	logic               accept, cat_ok, immediate;
	logic               issue, hit, scan_end, room, second_pass, out_free, out_load;
	logic [KEY_W-1:0]   search_key;

	assign accept    = s_tvalid && s_tready;
	assign cat_ok    = 32'(in_cat) < NUM_CATEGORIES;
	assign immediate = disabled_q || !cat_ok;

	assign search_key  = pass_q ? '0 : key_q;
	assign issue       = rd_idx_q < n_q;
	assign hit         = pend_s1 && (ent_rdata.key == search_key);
	assign scan_end    = !pend_s1 && !issue;
	assign room        = n_q < SLOT_W'(TABLE_SLOTS - 1);
	// a lookup that missed a nonzero key falls back to the default key once
	assign second_pass = (cmd_q == CMD_LOOKUP) && !pass_q && (key_q != '0);
	assign out_free    = !m_tvalid_q || m_tready;
	assign out_load    = (state_q == ST_DONE) && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = immediate ? ST_DONE : ST_COUNT;
				end
			end
			ST_COUNT: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = (cmd_q == CMD_LOOKUP) ? ST_MAP : ST_DONE;
				end else if (scan_end && !second_pass) begin
					state_d = ST_DONE;
				end
			end
			ST_MAP: begin
				if (map_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs: handshake, memory ports, map start
	always_comb begin
		s_tready  = 1'b0;
		cnt_rd    = 1'b0;
		cnt_we    = 1'b0;
		ent_ctl   = '0;
		ent_slot  = rd_idx_q;
		map_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cnt_rd   = s_tvalid && !immediate;
			end
			ST_SCAN: begin
				if (hit) begin
					// rewrite the matched entry in place, or start the map
					ent_ctl.wr_en = (cmd_q == CMD_DEFINE);
					ent_slot      = idx_s1;
					map_start     = (cmd_q == CMD_LOOKUP);
				end else if (scan_end) begin
					// append a new key behind the last entry
					ent_ctl.wr_en = (cmd_q == CMD_DEFINE) && room;
					cnt_we        = (cmd_q == CMD_DEFINE) && room;
					ent_slot      = n_q;
				end else begin
					ent_ctl.rd_en = issue;
				end
			end
			default: begin
			end
		endcase
	end

	assign ent_addr = ENT_AW'(cat_q) * ENT_AW'(TABLE_SLOTS) + ENT_AW'(ent_slot);

	assign ent_wdata.key         = key_q;
	assign ent_wdata.sound       = sid_q;
	assign ent_wdata.pitch_high  = ph_q;
	assign ent_wdata.pitch_low   = pl_q;
	assign ent_wdata.volume_high = vh_q;
	assign ent_wdata.volume_low  = vl_q;

	kdl_entry_mem #(
		.DEPTH (DEPTH),
		.AW    (ENT_AW)
	) u_entry_mem (
		.clk   (clk),
		.ctl   (ent_ctl),
		.addr  (ent_addr),
		.wdata (ent_wdata),
		.rdata (ent_rdata)
	);

	kdl_count_mem #(
		.DEPTH (NUM_CATEGORIES),
		.AW    (CNT_AW),
		.DW    (SLOT_W)
	) u_count_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (cnt_rd),
		.rd_addr (CNT_AW'(in_cat)),
		.rd_data (cnt_rdata),
		.wr_en   (cnt_we),
		.wr_addr (CNT_AW'(cat_q)),
		.wr_data (n_q + SLOT_W'(1))
	);

	kdl_vmap u_vmap (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (map_start),
		.volume_high    (ent_rdata.volume_high),
		.volume_low     (ent_rdata.volume_low),
		.volume_request (vreq_q),
		.clip_to_high   (clip_q),
		.done           (map_done),
		.mapped_volume  (map_vol)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			disabled_q <= 1'b0;
			pend_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				disabled_q <= cfg_data;
			end
			// a read is in flight only while the scan keeps walking
			pend_s1 <= (state_q == ST_SCAN) && !hit && !scan_end && issue;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// command, scan and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= kdl_cmd_t'(s_tuser);
			cat_q     <= in_cat;
			key_q     <= in_key;
			sid_q     <= in_sid;
			ph_q      <= in_ph;
			pl_q      <= in_pl;
			vh_q      <= in_vh;
			vl_q      <= in_vl;
			vreq_q    <= in_vreq;
			clip_q    <= in_clip;
			res_sid_q <= '0;
			res_ph_q  <= '0;
			res_pl_q  <= '0;
			res_vol_q <= '0;
			// preset the outcome of a command that finds nothing
			if (disabled_q) begin
				res_status_q <= STAT_DISABLED;
			end else if (kdl_cmd_t'(s_tuser) == CMD_DEFINE) begin
				res_status_q <= STAT_FULL;
			end else begin
				res_status_q <= STAT_MISS;
			end
		end

		if (state_q == ST_COUNT) begin
			n_q      <= cnt_rdata;
			rd_idx_q <= '0;
			pass_q   <= 1'b0;
		end

		if (state_q == ST_SCAN) begin
			if (hit) begin
				if (cmd_q == CMD_DEFINE) begin
					res_status_q <= STAT_REDEFINED;
				end else begin
					res_status_q <= pass_q ? STAT_DEFAULT : STAT_EXACT;
					res_sid_q    <= ent_rdata.sound;
					res_ph_q     <= ent_rdata.pitch_high;
					res_pl_q     <= ent_rdata.pitch_low;
				end
			end else if (scan_end) begin
				if (second_pass) begin
					pass_q   <= 1'b1;
					rd_idx_q <= '0;
				end else if ((cmd_q == CMD_DEFINE) && room) begin
					res_status_q <= STAT_ADDED;
				end
			end else if (issue) begin
				idx_s1   <= rd_idx_q;
				rd_idx_q <= rd_idx_q + SLOT_W'(1);
			end
		end

		if ((state_q == ST_MAP) && map_done) begin
			res_vol_q <= map_vol;
		end

		if (out_load) begin
			m_tdata_q <= {1'b0, res_vol_q, res_pl_q, res_ph_q, res_sid_q};
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== hw/rtl/kdl_checker.sv =====
// ---------------------------------------------------------------------------
// kdl_checker: port-level checks for the keyed table lookup block
// Watches the command and result streams; bound to the top level below.
// ---------------------------------------------------------------------------
module kdl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [kdl_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [kdl_pkg::STATUS_W-1:0]  m_tuser
);
	import kdl_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one command in flight at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command taken while another is in flight");

	// only hits carry entry data
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_EXACT) && (m_tuser != STAT_DEFAULT)
			|-> m_tdata == '0)
		else $error("non-hit result carries data");

	// mapped volume stays within full scale
	a_vol_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[78:64] <= FULL_SCALE)
		else $error("mapped volume above full scale");

endmodule

bind keyed_table_with_default_lookup kdl_checker u_kdl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== verif/keyed_table_with_default_lookup_checker.sv =====
// ---------------------------------------------------------------------------
// keyed_table_with_default_lookup_checker: result scoreboard for the table
// Watches the configuration port and both streams, keeps its own copy of the
// per-category tables, predicts one result per accepted command and compares
// every accepted result against the oldest prediction.
// ---------------------------------------------------------------------------
module keyed_table_with_default_lookup_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_data,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [kdl_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [kdl_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [kdl_pkg::STATUS_W-1:0]  m_tuser,
	output int                            fail_count,
	output int                            open_count,
	output int                            result_count,
	output logic [6:0]                    status_seen
);
	import kdl_pkg::*;

	localparam int CATS         = NUM_CATEGORIES_DEF;
	localparam int SLOTS        = TABLE_SLOTS_DEF;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		kdl_status_t        status;
		logic [SID_W-1:0]   sound;
		logic [PITCH_W-1:0] pitch_high;
		logic [PITCH_W-1:0] pitch_low;
		logic [VOL_W-1:0]   volume;
	} table_result_t;

	logic          sound_off = 1'b0;
	int            fill_level [CATS];
	kdl_entry_t    entries [CATS][SLOTS];
	table_result_t expected_q [$];
	int            mismatches = 0;
	int            seen = 0;
	logic [6:0]    seen_mask = '0;

	function automatic int find_slot(int cat, logic [KEY_W-1:0] key);
		for (int i = 0; i < fill_level[cat]; i++)
			if (entries[cat][i].key == key)
				return i;
		return -1;
	endfunction

	// Update the table copy for one command and return the result it causes.
	function automatic table_result_t apply_command(kdl_cmd_t cmd, int cat, kdl_entry_t op,
			logic [VOL_W-1:0] vreq, logic clip);
		table_result_t r;
		int            slot;
		longint        hi, lo, v, scale;
		r = '0;
		scale = FULL_SCALE;
		if (sound_off) begin
			r.status = STAT_DISABLED;
			return r;
		end
		if (cmd == CMD_DEFINE) begin
			slot = find_slot(cat, op.key);
			if (slot >= 0) begin
				r.status = STAT_REDEFINED;
			end else if (fill_level[cat] >= SLOTS - 1) begin
				r.status = STAT_FULL;
				return r;
			end else begin
				slot = fill_level[cat];
				fill_level[cat]++;
				r.status = STAT_ADDED;
			end
			entries[cat][slot] = op;
			return r;
		end
		r.status = STAT_EXACT;
		slot = find_slot(cat, op.key);
		if (slot < 0) begin
			r.status = STAT_DEFAULT;
			slot = find_slot(cat, '0);
		end
		if (slot < 0) begin
			r.status = STAT_MISS;
			return r;
		end
		r.sound      = entries[cat][slot].sound;
		r.pitch_high = entries[cat][slot].pitch_high;
		r.pitch_low  = entries[cat][slot].pitch_low;
		hi = entries[cat][slot].volume_high;
		lo = entries[cat][slot].volume_low;
		v  = vreq;
		// a 0..100 percent entry passes the request through; signed division truncates
		if (!(lo == 0 && hi == scale))
			v = lo + (hi - lo) * v / scale;
		if (clip && v > hi)
			v = hi;
		if (v < 0)
			v = 0;
		if (v > scale)
			v = scale;
		r.volume = v[VOL_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		kdl_entry_t    op;
		table_result_t want, got;
		if (!arst_n) begin
			sound_off = 1'b0;
			for (int c = 0; c < CATS; c++)
				fill_level[c] = 0;
			expected_q.delete();
			mismatches = 0;
			seen = 0;
			seen_mask = '0;
			fail_count   <= 0;
			open_count   <= 0;
			result_count <= 0;
			status_seen  <= '0;
		end else begin
			if (cfg_we)
				sound_off = cfg_data;
			if (s_tvalid && s_tready) begin
				op.key         = s_tdata[10:3];
				op.sound       = s_tdata[42:11];
				op.pitch_high  = s_tdata[58:43];
				op.pitch_low   = s_tdata[74:59];
				op.volume_high = s_tdata[89:75];
				op.volume_low  = s_tdata[104:90];
				want = apply_command(kdl_cmd_t'(s_tuser), int'(s_tdata[2:0]), op,
					s_tdata[119:105], s_tdata[120]);
				expected_q.push_back(want);
				seen_mask[want.status] = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				got.status     = kdl_status_t'(m_tuser);
				got.sound      = m_tdata[31:0];
				got.pitch_high = m_tdata[47:32];
				got.pitch_low  = m_tdata[63:48];
				got.volume     = m_tdata[78:64];
				seen++;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("result %0d arrived with nothing expected: status %0d sound %h",
							seen, got.status, got.sound);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("result %0d mismatch: expected status %0d sound %h pitch %h/%h volume %0d",
								seen, want.status, want.sound, want.pitch_high, want.pitch_low,
								want.volume);
							$display("  got status %0d sound %h pitch %h/%h volume %0d",
								got.status, got.sound, got.pitch_high, got.pitch_low,
								got.volume);
						end
					end
				end
			end
			fail_count   <= mismatches;
			open_count   <= expected_q.size();
			result_count <= seen;
			status_seen  <= seen_mask;
		end
	end

endmodule

// ===== verif/keyed_table_with_default_lookup_test.sv =====
// ---------------------------------------------------------------------------
// keyed_table_with_default_lookup_test: stimulus and verdict for the table
// Drives define and lookup commands into the block, toggles the disable flag
// between phases, idles both stream sides at random and lets the checker
// score every result.
// ---------------------------------------------------------------------------
module keyed_table_with_default_lookup_test;
	import kdl_pkg::*;

	localparam int RANDOM_ITEMS   = 1110;
	localparam int PHASES         = 6;
	localparam int TAIL_CYCLES    = 60;    // above the worst-case command latency
	localparam int LONG_HOLD      = 400;   // receiver hold-off under pressure
	localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer

	// one command as the sender sees it
	typedef struct packed {
		kdl_cmd_t           cmd;
		logic [CAT_W-1:0]   cat;
		logic [KEY_W-1:0]   key;
		logic [SID_W-1:0]   sound;
		logic [PITCH_W-1:0] pitch_high;
		logic [PITCH_W-1:0] pitch_low;
		logic [VOL_W-1:0]   volume_high;
		logic [VOL_W-1:0]   volume_low;
		logic [VOL_W-1:0]   volume_request;
		logic               clip;
	} sound_cmd_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic                 cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // category, key, sound id, pitches, volumes, clip
	logic                 s_tuser;   // command
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // sound id, pitch high, pitch low, mapped volume
	logic [STATUS_W-1:0]  m_tuser;   // status

	int         fail_count;
	int         open_count;
	int         result_count;
	logic [6:0] status_seen;

	// shared between the sender and the receiver process
	bit hold_request = 1'b0;
	bit no_idle      = 1'b0;
	int sent         = 0;
	int cfg_writes   = 0;

	keyed_table_with_default_lookup i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	keyed_table_with_default_lookup_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.open_count   (open_count),
		.result_count (result_count),
		.status_seen  (status_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Volumes: the legal range most of the time, the edges and the rest of the
	// 15-bit field often enough to hit saturation and negative slopes.
	function automatic logic [VOL_W-1:0] pick_volume();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return '0;
		if (r < 24)
			return FULL_SCALE;
		if (r < 30)
			return '1;
		if (r < 45)
			return VOL_W'($urandom_range(0, 32767));
		return VOL_W'($urandom_range(0, 25600));
	endfunction

	function automatic sound_cmd_t command_of(kdl_cmd_t cmd, logic [CAT_W-1:0] cat,
			logic [KEY_W-1:0] key, logic [SID_W-1:0] sound, logic [PITCH_W-1:0] ph,
			logic [PITCH_W-1:0] pl, logic [VOL_W-1:0] vh, logic [VOL_W-1:0] vl,
			logic [VOL_W-1:0] vreq, logic clip);
		sound_cmd_t c;
		c.cmd            = cmd;
		c.cat            = cat;
		c.key            = key;
		c.sound          = sound;
		c.pitch_high     = ph;
		c.pitch_low      = pl;
		c.volume_high    = vh;
		c.volume_low     = vl;
		c.volume_request = vreq;
		c.clip           = clip;
		return c;
	endfunction

	// Offer one command and hold it until the transfer. Valid stays high on
	// return, so a back-to-back command only replaces the data.
	task automatic send_command(sound_cmd_t c);
		logic [S_TDATA_W-1:0] d;
		d = '0;
		d[2:0]     = c.cat;
		d[10:3]    = c.key;
		d[42:11]   = c.sound;
		d[58:43]   = c.pitch_high;
		d[74:59]   = c.pitch_low;
		d[89:75]   = c.volume_high;
		d[104:90]  = c.volume_low;
		d[119:105] = c.volume_request;
		d[120]     = c.clip;
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= c.cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic sender_gap();
		int n;
		n = no_idle ? 0 : pick_gap();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drop valid and hold until every predicted result has come back, then
	// let the block settle before anything touches the register.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(logic disabled);
		cfg_we   <= 1'b1;
		cfg_data <= disabled;
		@(posedge clk);
		cfg_we   <= 1'b0;
		cfg_writes++;
	endtask

	// Receiver: random ready with gaps, a long hold-off on request, and
	// always-ready during the no-idle phase.
	initial begin
		int gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end else if (no_idle) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Watchdog: end the run when no transfer happens on either side for too long.
	initial begin
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

	initial begin
		sound_cmd_t directed_q [$];
		sound_cmd_t c;
		int         r;
		logic [7:0] key;

		arst_n   <= 1'b0;
		cfg_we   <= 1'b0;
		cfg_data <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, full-range pass-through, missing default,
		// default fallback, redefine with a falling range, clipping, saturation
		// at both ends and key 0 matched exactly.
		directed_q.push_back(command_of(CMD_LOOKUP, 3'd0, 8'd5, '0, '0, '0, '0, '0, 15'd12800, 1'b0));
		directed_q.push_back(command_of(CMD_DEFINE, 3'd0, 8'd5, '1, '1, '0, FULL_SCALE, '0, '0, 1'b0));
		directed_q.push_back(command_of(CMD_LOOKUP, 3'd0, 8'd5, '0, '0, '0, '0, '0, '1, 1'b0));
		directed_q.push_back(command_of(CMD_LOOKUP, 3'd0, 8'd9, '0, '0, '0, '0, '0, '0, 1'b0));
		directed_q.push_back(command_of(CMD_DEFINE, 3'd0, 8'd0, '0, '0, '1, 15'd20000, 15'd5000,
			'0, 1'b0));
		directed_q.push_back(command_of(CMD_LOOKUP, 3'd0, 8'd9, '0, '0, '0, '0, '0, 15'd12800, 1'b1));
		directed_q.push_back(command_of(CMD_DEFINE, 3'd0, 8'd5, 32'h1234, 16'h8000, 16'h7fff,
			15'd1000, 15'd30000, '0, 1'b0));
		directed_q.push_back(command_of(CMD_LOOKUP, 3'd0, 8'd5, '0, '0, '0, '0, '0, FULL_SCALE, 1'b0));
		directed_q.push_back(command_of(CMD_LOOKUP, 3'd0, 8'd5, '0, '0, '0, '0, '0, '0, 1'b1));
		directed_q.push_back(command_of(CMD_DEFINE, 3'd7, 8'd255, 32'h8000_0001, 16'h0001, 16'hfffe,
			'1, '1, '0, 1'b0));
		directed_q.push_back(command_of(CMD_LOOKUP, 3'd7, 8'd255, '0, '0, '0, '0, '0, '0, 1'b0));
		directed_q.push_back(command_of(CMD_LOOKUP, 3'd7, 8'd0, '0, '0, '0, '0, '0, '0, 1'b0));
		directed_q.push_back(command_of(CMD_DEFINE, 3'd3, 8'd1, 32'h5555_aaaa, 16'haaaa, 16'h5555,
			'0, FULL_SCALE, '0, 1'b0));
		directed_q.push_back(command_of(CMD_LOOKUP, 3'd3, 8'd1, '0, '0, '0, '0, '0, '1, 1'b0));
		directed_q.push_back(command_of(CMD_DEFINE, 3'd3, 8'd0, 32'd7, '0, '0, FULL_SCALE, '0,
			'0, 1'b0));
		directed_q.push_back(command_of(CMD_LOOKUP, 3'd3, 8'd200, '0, '0, '0, '0, '0, 15'd17, 1'b1));
		directed_q.push_back(command_of(CMD_LOOKUP, 3'd3, 8'd0, '0, '0, '0, '0, '0, FULL_SCALE, 1'b0));
		directed_q.push_back(command_of(CMD_DEFINE, 3'd2, 8'd8, 32'd1, '0, '0, '0, '0, '0, 1'b0));
		directed_q.push_back(command_of(CMD_LOOKUP, 3'd2, 8'd8, '0, '0, '0, '0, '0, '1, 1'b1));
		foreach (directed_q[i]) begin
			send_command(directed_q[i]);
			sender_gap();
		end
		drain();

		// Disabled: both commands report disabled and leave the tables alone.
		write_config(1'b1);
		send_command(command_of(CMD_DEFINE, 3'd0, 8'd77, '1, '1, '1, '1, '1, '1, 1'b1));
		send_command(command_of(CMD_LOOKUP, 3'd0, 8'd5, '0, '0, '0, '0, '0, FULL_SCALE, 1'b0));
		drain();
		write_config(1'b0);

		// Fill one table to capacity, overflow it, then redefine a present key.
		for (int k = 1; k <= TABLE_SLOTS_DEF; k++) begin
			send_command(command_of(CMD_DEFINE, 3'd5, 8'(k), $urandom, 16'($urandom),
				16'($urandom), pick_volume(), pick_volume(), '0, 1'b0));
			sender_gap();
		end
		send_command(command_of(CMD_DEFINE, 3'd5, 8'd3, $urandom, '0, '0, FULL_SCALE, '0,
			'0, 1'b0));
		send_command(command_of(CMD_LOOKUP, 3'd5, 8'(TABLE_SLOTS_DEF), '0, '0, '0, '0, '0,
			pick_volume(), 1'b1));
		sender_gap();

		// Random phases: keys from a small pool so defines collide and lookups
		// hit; one phase disabled, one under a long receiver hold-off, one with
		// no idling on either side.
		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_config(p == 3);
			no_idle = (p == 4);
			if (p == 1)
				hold_request = 1'b1;
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				r = $urandom_range(0, 99);
				if (r < 20)
					key = '0;
				else if (r < 80)
					key = 8'($urandom_range(1, 20));
				else
					key = 8'($urandom_range(0, 255));
				c = command_of(kdl_cmd_t'($urandom_range(0, 1)), CAT_W'($urandom_range(0, 7)),
					key, $urandom, 16'($urandom), 16'($urandom), pick_volume(), pick_volume(),
					pick_volume(), 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 9) == 0) begin
					c.volume_high = FULL_SCALE;
					c.volume_low  = '0;
				end
				send_command(c);
				sender_gap();
			end
		end
		no_idle = 1'b0;
		drain();

		$display("checked %0d results for %0d commands; status codes seen (bit per code): %b",
			result_count, sent, status_seen);
		$display("disable flag written %0d times; one long output stall, one gap-free phase",
			cfg_writes);
		if (fail_count == 0 && open_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d results never arrived", fail_count, open_count);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
